>>> hw/rtl/sslj_pkg.sv
// Shared types and constants for the stepper soft-limit jog controller.
// No dependencies; imported by every module of the block.
package sslj_pkg;

   // Width of the internal position and away-limit registers
   localparam int POSITION_BITS = 16;
   localparam logic [15:0] PENDING_MAX = 16'hFFFF;
   localparam logic [7:0] STEPS_PER_NEEDLE_RST = 8'd1;
   localparam logic [14:0] MAX_TRAVEL_RST = 15'd32767;
   // move amount = digit * MOVE_SCALE + 1
   localparam logic [6:0] MOVE_SCALE = 7'd5;

   typedef logic signed [POSITION_BITS-1:0] pos_type;

   typedef enum logic [3:0] {
      CMD_TICK   = 4'd0,
      CMD_ABORT  = 4'd1,
      CMD_CLEAR  = 4'd2,
      CMD_GO     = 4'd3,
      CMD_HOME   = 4'd4,
      CMD_AWAY   = 4'd5,
      CMD_LEFT   = 4'd6,
      CMD_RIGHT  = 4'd7,
      CMD_NEEDLE = 4'd8,
      CMD_STEP   = 4'd9,
      CMD_MOVE   = 4'd10,
      CMD_STATUS = 4'd11,
      CMD_NOP    = 4'd12
   } cmd_type;

   typedef enum logic [4:0] {
      MSG_NONE        = 5'd0,
      MSG_NOP         = 5'd1,
      MSG_ABORT       = 5'd2,
      MSG_CLEARED     = 5'd3,
      MSG_GOING       = 5'd4,
      MSG_NEED_BOTH   = 5'd5,
      MSG_HOMED       = 5'd6,
      MSG_AWAYED      = 5'd7,
      MSG_NEED_HOME   = 5'd8,
      MSG_LEFT        = 5'd9,
      MSG_RIGHT       = 5'd10,
      MSG_NEEDLE      = 5'd11,
      MSG_STEP        = 5'd12,
      MSG_DONE        = 5'd13,
      MSG_LEFT_LIMIT  = 5'd14,
      MSG_RIGHT_LIMIT = 5'd15,
      MSG_STATUS      = 5'd16
   } msg_type;

   // Register indexes on the configuration port
   typedef enum logic {
      REG_STEPS_PER_NEEDLE = 1'b0,
      REG_MAX_TRAVEL       = 1'b1
   } reg_type;

   typedef struct packed {
      logic [3:0] cmd;
      logic [3:0] digit;
   } req_type;

   typedef struct packed {
      logic              step_pulse;
      logic              direction_left;
      msg_type           message;
      logic signed [15:0] position;
      logic signed [15:0] away_position;
      logic              is_homed;
      logic              is_awayed;
      logic              in_needle_mode;
      logic [15:0]       steps_pending;
      logic              running_free;
   } rsp_type;

   // Configuration values handed from the register file to the core
   typedef struct packed {
      logic [7:0]  steps_per_needle;
      logic [14:0] max_travel;
   } cfg_type;

endpackage

>>> hw/rtl/stepper_soft_limit_jog_controller_unit.sv
// Stepper jog controller with soft limits: one command or tick item per cycle, one result item
// each. Items pass an input register, combinational state update logic, and a result register;
// a new item is taken every cycle as long as the result side keeps up, the rate being set by
// the single state-update pass. Configuration registers (steps_per_needle at 0x0, max_travel
// at 0x4) must be written only while the block is idle; the block itself does not enforce this.
// Depends on sslj_pkg, sslj_csr and sslj_core.
module stepper_soft_limit_jog_controller_unit
   import sslj_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg;
   req_type in_item_ff, in_item_in;
   logic    in_valid_ff, in_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type core_result;
   logic    advance;
   logic    req_fire;

   sslj_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sslj_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   // Item moves from input register to result register when the result slot frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_item_in   = req_fire ? req_data : in_item_ff;
      rsp_valid_in = advance ? 1'b1 : ((rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = advance ? core_result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A held input item is neither dropped nor overwritten while the result side stalls
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("input item lost while stalled");

   // An item only enters the core when the result slot can take it
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      advance |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overrun");

   // A stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("result changed while stalled");

endmodule

>>> hw/rtl/sslj_csr.sv
// Configuration register file on an APB-style port.
// Depends on sslj_pkg for the register indexes and the cfg_type bundle.
module sslj_csr
   import sslj_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [7:0]  steps_per_needle_ff, steps_per_needle_in;
   logic [14:0] max_travel_ff, max_travel_in;
   logic        wr_en;
   reg_type     reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = reg_type'(csr_paddr[2]);

   // Write decode
   always_comb begin
      steps_per_needle_in = steps_per_needle_ff;
      max_travel_in       = max_travel_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_STEPS_PER_NEEDLE: steps_per_needle_in = csr_pwdata[7:0];
            REG_MAX_TRAVEL:       max_travel_in       = csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_per_needle_ff <= STEPS_PER_NEEDLE_RST;
         max_travel_ff       <= MAX_TRAVEL_RST;
      end else begin
         steps_per_needle_ff <= steps_per_needle_in;
         max_travel_ff       <= max_travel_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_sel)
         REG_STEPS_PER_NEEDLE: csr_prdata = {24'd0, steps_per_needle_ff};
         REG_MAX_TRAVEL:       csr_prdata = {17'd0, max_travel_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   assign cfg.steps_per_needle = steps_per_needle_ff;
   assign cfg.max_travel       = max_travel_ff;

endmodule

>>> hw/rtl/sslj_core.sv
// Jog controller state and combinational command/tick update logic.
// Depends on sslj_pkg; the result it forms is registered by the top level.
module sslj_core
   import sslj_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam pos_type POS_MAX = pos_type'({1'b0, {(POSITION_BITS-1){1'b1}}});
   localparam pos_type POS_MIN = pos_type'({1'b1, {(POSITION_BITS-1){1'b0}}});

   pos_type     position_ff, position_in;
   pos_type     away_ff, away_in;
   logic [15:0] pending_ff, pending_in;
   logic        free_run_ff, free_run_in;
   logic        was_stepping_ff, was_stepping_in;
   logic        homed_ff, homed_in;
   logic        awayed_ff, awayed_in;
   logic        left_ff, left_in;
   logic        needle_ff, needle_in;

   logic        pulse;
   msg_type     msg;
   logic        step_ok;
   logic [6:0]  base_amount;
   logic [14:0] amount;
   logic [16:0] queue_sum;
   cmd_type     cmd;

   assign cmd = cmd_type'(item.cmd);

   // Move amount: (digit*5+1) steps, times steps_per_needle in needle units
   assign base_amount = 7'({3'b000, item.digit} * MOVE_SCALE) + 7'd1;
   assign amount      = needle_ff ? (15'(base_amount) * 15'(cfg.steps_per_needle))
                                  : {8'd0, base_amount};
   assign queue_sum   = {1'b0, pending_ff} + {2'b00, amount};

   // Soft limit check for a tick
   assign step_ok = left_ff ? (!awayed_ff || (position_ff < away_ff))
                            : (!homed_ff || (position_ff > pos_type'(0)));

   // Next state and message for one item
   always_comb begin
      position_in     = position_ff;
      away_in         = away_ff;
      pending_in      = pending_ff;
      free_run_in     = free_run_ff;
      was_stepping_in = was_stepping_ff;
      homed_in        = homed_ff;
      awayed_in       = awayed_ff;
      left_in         = left_ff;
      needle_in       = needle_ff;
      pulse           = 1'b0;
      msg             = MSG_NOP;
      case (cmd)
         CMD_TICK: begin
            if (!free_run_ff && (pending_ff == 16'd0)) begin
               was_stepping_in = 1'b0;
               msg = was_stepping_ff ? MSG_DONE : MSG_NONE;
            end else if (!step_ok) begin
               pending_in      = 16'd0;
               was_stepping_in = 1'b0;
               free_run_in     = 1'b0;
               msg = left_ff ? MSG_LEFT_LIMIT : MSG_RIGHT_LIMIT;
            end else begin
               was_stepping_in = 1'b1;
               pulse           = 1'b1;
               msg             = MSG_NONE;
               if (left_ff) begin
                  if (position_ff != POS_MAX) position_in = position_ff + pos_type'(1);
               end else begin
                  if (position_ff != POS_MIN) position_in = position_ff - pos_type'(1);
               end
               if (!free_run_ff && (pending_ff != 16'd0)) pending_in = pending_ff - 16'd1;
            end
         end
         CMD_ABORT: begin
            pending_in      = 16'd0;
            was_stepping_in = 1'b0;
            free_run_in     = 1'b0;
            msg             = MSG_ABORT;
         end
         CMD_CLEAR: begin
            pending_in      = 16'd0;
            was_stepping_in = 1'b0;
            free_run_in     = 1'b0;
            homed_in        = 1'b0;
            awayed_in       = 1'b0;
            position_in     = pos_type'(0);
            away_in         = pos_type'(cfg.max_travel);
            msg             = MSG_CLEARED;
         end
         CMD_GO: begin
            if (homed_ff && awayed_ff) begin
               free_run_in     = 1'b1;
               pending_in      = 16'd0;
               was_stepping_in = 1'b0;
               msg             = MSG_GOING;
            end else begin
               msg = MSG_NEED_BOTH;
            end
         end
         CMD_HOME: begin
            homed_in        = 1'b1;
            position_in     = pos_type'(0);
            pending_in      = 16'd0;
            was_stepping_in = 1'b0;
            free_run_in     = 1'b0;
            msg             = MSG_HOMED;
         end
         CMD_AWAY: begin
            if (homed_ff) begin
               awayed_in       = 1'b1;
               away_in         = position_ff;
               pending_in      = 16'd0;
               was_stepping_in = 1'b0;
               free_run_in     = 1'b0;
               msg             = MSG_AWAYED;
            end else begin
               msg = MSG_NEED_HOME;
            end
         end
         CMD_LEFT: begin
            left_in = 1'b1;
            msg     = MSG_LEFT;
         end
         CMD_RIGHT: begin
            left_in = 1'b0;
            msg     = MSG_RIGHT;
         end
         CMD_NEEDLE: begin
            needle_in = 1'b1;
            msg       = MSG_NEEDLE;
         end
         CMD_STEP: begin
            needle_in = 1'b0;
            msg       = MSG_STEP;
         end
         CMD_MOVE: begin
            pending_in = queue_sum[16] ? PENDING_MAX : queue_sum[15:0];
            msg        = MSG_NOP;
         end
         CMD_STATUS: msg = MSG_STATUS;
         // nop and unused codes
         default: msg = MSG_NOP;
      endcase
   end

   // State registers, updated once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff     <= pos_type'(0);
         away_ff         <= pos_type'(MAX_TRAVEL_RST);
         pending_ff      <= 16'd0;
         free_run_ff     <= 1'b0;
         was_stepping_ff <= 1'b0;
         homed_ff        <= 1'b0;
         awayed_ff       <= 1'b0;
         left_ff         <= 1'b1;
         needle_ff       <= 1'b0;
      end else if (fire) begin
         position_ff     <= position_in;
         away_ff         <= away_in;
         pending_ff      <= pending_in;
         free_run_ff     <= free_run_in;
         was_stepping_ff <= was_stepping_in;
         homed_ff        <= homed_in;
         awayed_ff       <= awayed_in;
         left_ff         <= left_in;
         needle_ff       <= needle_in;
      end
   end

   // Result fields reflect the state after the item
   always_comb begin
      result.step_pulse     = pulse;
      result.direction_left = left_in;
      result.message        = msg;
      result.position       = 16'(position_in);
      result.away_position  = 16'(away_in);
      result.is_homed       = homed_in;
      result.is_awayed      = awayed_in;
      result.in_needle_mode = needle_in;
      result.steps_pending  = pending_in;
      result.running_free   = free_run_in;
   end

   // Free run is only ever entered with both limits set
   a_free_needs_limits: assert property (@(posedge clock) disable iff (reset)
      free_run_ff |-> (homed_ff && awayed_ff))
      else $error("free run without home and away");

   // Away can only be marked after home
   a_away_needs_home: assert property (@(posedge clock) disable iff (reset)
      awayed_ff |-> homed_ff)
      else $error("away set without home");

   // An accepted abort leaves no motion behind
   a_abort_stops: assert property (@(posedge clock) disable iff (reset)
      (fire && (item.cmd == CMD_ABORT)) |=> (pending_ff == 16'd0) && !free_run_ff)
      else $error("abort left motion pending");

   // A pulse comes only from a tick
   a_pulse_on_tick: assert property (@(posedge clock) disable iff (reset)
      (fire && pulse) |-> (item.cmd == CMD_TICK))
      else $error("step pulse outside a tick");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking bench for the stepper soft-limit jog controller: random and directed
// command/tick items against an in-bench state predictor. Depends on sslj_pkg and the unit.
`timescale 1ns / 100ps

module tb_top;
   import sslj_pkg::*;

   // Receiver/sender pacing styles
   typedef enum int {
      PACE_NONE,
      PACE_SPREAD,
      PACE_SPARSE
   } pace_type;

   localparam int CYCLE_LIMIT = 600000;
   localparam int LONG_HOLD_CYCLES = 90;
   localparam pos_type POS_TOP = {1'b0, {(POSITION_BITS-1){1'b1}}};
   localparam pos_type POS_BOTTOM = {1'b1, {(POSITION_BITS-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   stepper_soft_limit_jog_controller_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // Jog state as the bench predicts it
   pos_type jog_pos;
   pos_type jog_away;
   logic [15:0] jog_pending;
   logic jog_free;
   logic jog_was_moving;
   logic jog_homed;
   logic jog_awayed;
   logic jog_left;
   logic jog_needle;
   logic [7:0] cfg_needle_steps;
   logic [14:0] cfg_travel;

   req_type jog_items[$];
   rsp_type expected_status[$];
   pace_type pace_mode = PACE_SPREAD;

   int items_pushed = 0;
   int items_taken = 0;
   int results_seen = 0;
   int fail_count = 0;
   int settings_count = 0;
   int cycle_count = 0;
   int send_wait = 0;
   int recv_wait = 0;
   int long_hold = 0;
   int results_released = 0;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   function automatic int draw_wait(pace_type mode);
      case (mode)
         PACE_NONE: return 0;
         PACE_SPREAD: return $urandom_range(0, 11);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
      endcase
   endfunction

   function automatic void reset_jog_model();
      cfg_needle_steps = STEPS_PER_NEEDLE_RST;
      cfg_travel = MAX_TRAVEL_RST;
      jog_pos = '0;
      jog_away = {1'b0, MAX_TRAVEL_RST};
      jog_pending = '0;
      jog_free = 1'b0;
      jog_was_moving = 1'b0;
      jog_homed = 1'b0;
      jog_awayed = 1'b0;
      jog_left = 1'b1;
      jog_needle = 1'b0;
   endfunction

   function automatic void halt_motion();
      jog_pending = '0;
      jog_was_moving = 1'b0;
      jog_free = 1'b0;
   endfunction

   // One command or tick applied to the predicted state; returns the status item it gives
   function automatic rsp_type advance_jog(req_type it);
      rsp_type r;
      msg_type msg;
      logic pulse;
      logic may_step;
      int unsigned amount;
      pulse = 1'b0;
      msg = MSG_NOP;
      may_step = 1'b0;
      case (it.cmd)
         CMD_TICK: begin
            if (!jog_free && jog_pending == 16'd0) begin
               // idle: report completion once after motion ends
               msg = jog_was_moving ? MSG_DONE : MSG_NONE;
               jog_was_moving = 1'b0;
            end else begin
               jog_was_moving = 1'b1;
               if (jog_left) may_step = !jog_awayed || (jog_pos < jog_away);
               else may_step = !jog_homed || (jog_pos > pos_type'(0));
               if (!may_step) begin
                  halt_motion();
                  msg = jog_left ? MSG_LEFT_LIMIT : MSG_RIGHT_LIMIT;
               end else begin
                  pulse = 1'b1;
                  // position saturates, the pulse still goes out
                  if (jog_left) begin
                     if (jog_pos != POS_TOP) jog_pos = jog_pos + pos_type'(1);
                  end else if (jog_pos != POS_BOTTOM) begin
                     jog_pos = jog_pos - pos_type'(1);
                  end
                  if (!jog_free && jog_pending != 16'd0) jog_pending = jog_pending - 16'd1;
                  msg = MSG_NONE;
               end
            end
         end
         CMD_ABORT: begin
            halt_motion();
            msg = MSG_ABORT;
         end
         CMD_CLEAR: begin
            halt_motion();
            jog_homed = 1'b0;
            jog_awayed = 1'b0;
            jog_pos = '0;
            jog_away = {1'b0, cfg_travel};
            msg = MSG_CLEARED;
         end
         CMD_GO: begin
            if (jog_homed && jog_awayed) begin
               jog_free = 1'b1;
               jog_pending = '0;
               jog_was_moving = 1'b0;
               msg = MSG_GOING;
            end else begin
               msg = MSG_NEED_BOTH;
            end
         end
         CMD_HOME: begin
            jog_homed = 1'b1;
            jog_pos = '0;
            halt_motion();
            msg = MSG_HOMED;
         end
         CMD_AWAY: begin
            if (jog_homed) begin
               jog_awayed = 1'b1;
               jog_away = jog_pos;
               halt_motion();
               msg = MSG_AWAYED;
            end else begin
               msg = MSG_NEED_HOME;
            end
         end
         CMD_LEFT: begin
            jog_left = 1'b1;
            msg = MSG_LEFT;
         end
         CMD_RIGHT: begin
            jog_left = 1'b0;
            msg = MSG_RIGHT;
         end
         CMD_NEEDLE: begin
            jog_needle = 1'b1;
            msg = MSG_NEEDLE;
         end
         CMD_STEP: begin
            jog_needle = 1'b0;
            msg = MSG_STEP;
         end
         CMD_MOVE: begin
            // digit used as given, pending count saturates
            amount = it.digit * MOVE_SCALE + 1;
            if (jog_needle) amount = amount * cfg_needle_steps;
            amount = amount + jog_pending;
            jog_pending = (amount > PENDING_MAX) ? PENDING_MAX : amount[15:0];
            msg = MSG_NOP;
         end
         CMD_STATUS: msg = MSG_STATUS;
         default: msg = MSG_NOP;
      endcase
      r.step_pulse = pulse;
      r.direction_left = jog_left;
      r.message = msg;
      r.position = jog_pos;
      r.away_position = jog_away;
      r.is_homed = jog_homed;
      r.is_awayed = jog_awayed;
      r.in_needle_mode = jog_needle;
      r.steps_pending = jog_pending;
      r.running_free = jog_free;
      return r;
   endfunction

   function automatic string show_status(rsp_type r);
      return $sformatf({"pulse=%0b left=%0b msg=%0d pos=%0d away=%0d homed=%0b awayed=%0b ",
                        "needle=%0b pending=%0d free=%0b"},
                       r.step_pulse, r.direction_left, r.message, r.position,
                       r.away_position, r.is_homed, r.is_awayed, r.in_needle_mode,
                       r.steps_pending, r.running_free);
   endfunction

   task automatic compare_status(rsp_type got, rsp_type want);
      string bad;
      bad = "";
      if (got.step_pulse !== want.step_pulse) bad = {bad, " step_pulse"};
      if (got.direction_left !== want.direction_left) bad = {bad, " direction_left"};
      if (got.message !== want.message) bad = {bad, " message"};
      if (got.position !== want.position) bad = {bad, " position"};
      if (got.away_position !== want.away_position) bad = {bad, " away_position"};
      if (got.is_homed !== want.is_homed) bad = {bad, " is_homed"};
      if (got.is_awayed !== want.is_awayed) bad = {bad, " is_awayed"};
      if (got.in_needle_mode !== want.in_needle_mode) bad = {bad, " in_needle_mode"};
      if (got.steps_pending !== want.steps_pending) bad = {bad, " steps_pending"};
      if (got.running_free !== want.running_free) bad = {bad, " running_free"};
      if (bad != "") begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("item %0d mismatch in%s", results_seen, bad);
            $display("   expected %s", show_status(want));
            $display("   actual   %s", show_status(got));
         end
      end
   endtask

   // Predict on input acceptance, check on result acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
         reset_jog_model();
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (req_valid && req_ready) begin
            expected_status.push_back(advance_jog(req_data));
            items_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("item %0d arrived with nothing expected: %s",
                           results_seen, show_status(rsp_data));
            end else begin
               compare_status(rsp_data, expected_status.pop_front());
            end
            results_seen++;
         end
      end
   end

   // Driver: feeds pending items with a wait after each, drawn by the pacing mode
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else if (!req_valid || req_taken) begin
         if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (jog_items.size() != 0) begin
            req_data <= jog_items.pop_front();
            req_valid <= 1'b1;
            send_wait = draw_wait(pace_mode);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: random stalls plus two long hold-offs that back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
         long_hold = 0;
      end else begin
         if (rsp_taken) begin
            recv_wait = draw_wait(pace_mode);
            results_released++;
            if (results_released == 150 || results_released == 1000)
               long_hold = LONG_HOLD_CYCLES;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d results outstanding",
                  cycle_count, expected_status.size());
         $display("FAIL");
         $finish;
      end
   end

   task automatic push_item(logic [3:0] c, logic [3:0] d);
      req_type it;
      it.cmd = c;
      it.digit = d;
      jog_items.push_back(it);
      items_pushed++;
   endtask

   // digit is ignored outside moves, so it is randomized there
   task automatic push_cmd(cmd_type c);
      push_item(c, 4'($urandom_range(0, 15)));
   endtask

   task automatic push_ticks(int n);
      repeat (n) push_item(CMD_TICK, 4'($urandom_range(0, 15)));
   endtask

   task automatic wait_drained();
      while (items_taken != items_pushed || expected_status.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write followed by a read-back of the same register
   task automatic write_csr(reg_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_STEPS_PER_NEEDLE) cfg_needle_steps = value[7:0];
      else cfg_travel = value[14:0];
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value) begin
         fail_count++;
         if (fail_count <= 10)
            $display("register %0d reads back %0h, written %0h", idx, csr_prdata, value);
      end
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic apply_settings(logic [7:0] needle_steps, logic [14:0] travel);
      write_csr(REG_STEPS_PER_NEEDLE, {24'd0, needle_steps});
      write_csr(REG_MAX_TRAVEL, {17'd0, travel});
      settings_count++;
   endtask

   // Mostly well-formed jog and calibration sequences, some noise
   task automatic queue_random_items(int goal);
      int stop_at;
      int d;
      stop_at = items_pushed + goal;
      while (items_pushed < stop_at) begin
         d = $urandom_range(0, 15);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               push_cmd($urandom_range(0, 1) ? CMD_LEFT : CMD_RIGHT);
               if ($urandom_range(0, 2) == 0)
                  push_cmd($urandom_range(0, 1) ? CMD_NEEDLE : CMD_STEP);
               push_item(CMD_MOVE, 4'(d));
               push_ticks($urandom_range(0, 24));
            end
            4, 5: begin
               // home, jog out, mark away, then free-run into both limits
               push_cmd(CMD_HOME);
               push_cmd(CMD_LEFT);
               push_cmd(CMD_STEP);
               push_item(CMD_MOVE, 4'($urandom_range(0, 5)));
               push_ticks($urandom_range(1, 30));
               push_cmd(CMD_AWAY);
               push_cmd(CMD_RIGHT);
               push_cmd(CMD_GO);
               push_ticks($urandom_range(2, 32));
               push_cmd(CMD_LEFT);
               push_cmd(CMD_GO);
               push_ticks($urandom_range(2, 32));
            end
            6: begin
               case ($urandom_range(0, 3))
                  0: push_cmd(CMD_CLEAR);
                  1: push_cmd(CMD_ABORT);
                  2: push_cmd(CMD_STATUS);
                  default: push_cmd(CMD_NOP);
               endcase
            end
            7, 8: begin
               repeat ($urandom_range(1, 4))
                  push_item(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            end
            default: begin
               // free run broken off by a stop command
               push_cmd(CMD_GO);
               push_item(CMD_MOVE, 4'(d));
               push_ticks($urandom_range(0, 8));
               case ($urandom_range(0, 3))
                  0: push_cmd(CMD_ABORT);
                  1: push_cmd(CMD_HOME);
                  2: push_cmd(CMD_AWAY);
                  default: push_cmd(CMD_CLEAR);
               endcase
               push_ticks($urandom_range(0, 3));
            end
         endcase
      end
   endtask

   // Queue needle moves past the pending limit, then tick a short stretch
   task automatic queue_full_travel(cmd_type dir);
      push_cmd(CMD_CLEAR);
      push_cmd(dir);
      push_cmd(CMD_NEEDLE);
      repeat (4) push_item(CMD_MOVE, 4'd15);
      push_ticks(16);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed walk through every command and the corner cases
      pace_mode = PACE_SPREAD;
      push_cmd(CMD_STATUS);
      push_cmd(CMD_GO);
      push_cmd(CMD_AWAY);
      push_item(CMD_MOVE, 4'd0);
      push_ticks(3);
      push_cmd(CMD_HOME);
      push_cmd(CMD_RIGHT);
      push_item(CMD_MOVE, 4'd9);
      push_ticks(1);
      push_cmd(CMD_LEFT);
      push_item(CMD_MOVE, 4'd15);
      push_ticks(1);
      push_cmd(CMD_AWAY);
      push_cmd(CMD_RIGHT);
      push_cmd(CMD_GO);
      push_item(CMD_MOVE, 4'd2);
      push_ticks(1);
      push_cmd(CMD_LEFT);
      push_ticks(2);
      push_cmd(CMD_NEEDLE);
      push_item(CMD_MOVE, 4'd1);
      push_cmd(CMD_ABORT);
      push_item(4'd15, 4'd0);
      push_cmd(CMD_STEP);
      push_cmd(CMD_NOP);
      push_cmd(CMD_CLEAR);
      wait_drained();

      // Random phases, each under its own register settings and pacing
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               apply_settings(8'd255, 15'd0);
               pace_mode = PACE_SPREAD;
            end
            1: begin
               apply_settings(8'd0, 15'd32767);
               pace_mode = PACE_SPARSE;
            end
            2: begin
               apply_settings(8'($urandom_range(1, 254)), 15'($urandom_range(0, 32767)));
               pace_mode = PACE_NONE;
            end
            default: begin
               apply_settings(8'd1, 15'($urandom_range(1, 64)));
               pace_mode = PACE_SPREAD;
            end
         endcase
         push_cmd(CMD_CLEAR);
         queue_random_items(450);
         wait_drained();
      end

      // Pending count driven into saturation in both directions
      apply_settings(8'd255, MAX_TRAVEL_RST);
      pace_mode = PACE_NONE;
      queue_full_travel(CMD_LEFT);
      queue_full_travel(CMD_RIGHT);
      push_cmd(CMD_CLEAR);
      wait_drained();
      repeat (8) @(posedge clock);

      $display("covered %0d items under %0d register settings: jogs, calibrations, free runs,",
               items_taken, settings_count);
      $display("limit stops and pending saturation; %0d results, %0d mismatches",
               results_seen, fail_count);
      if (fail_count == 0 && expected_status.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
